// File: rtl/triangle_unit_normal_defines.svh
// Assertion macros for the triangle unit normal checker.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TUN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TUN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tun_pkg.sv
// Shared constants, types and width helpers for the triangle unit normal pipeline.
package tun_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NORM_FRAC_DEF  = 14;
    localparam int OUT_BITS       = 16;
    localparam int NORM_MSB       = 30;   // the largest normalized magnitude lands in [2^30, 2^31)
    localparam int NMAG_BITS      = 31;
    localparam int SUM_BITS       = 64;
    localparam int ROOT_BITS      = 32;

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] neg;
    } tun_ctl_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
        logic                       degen;
    } tun_res_t;

    function automatic int edge_shift(input int cb);
        return (cb > 30) ? cb - 30 : 0;
    endfunction

    function automatic int edge_bits(input int cb);
        return cb + 1 - edge_shift(cb);
    endfunction

endpackage

// File: rtl/tun_cross.sv
// Edge vectors, the six cross-product multipliers and the cross-product sign/magnitude.
module tun_cross #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF,
    parameter int MAG_BITS   = 2 * tun_pkg::edge_bits(tun_pkg::COORD_BITS_DEF)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] p [9],
    output tun_pkg::tun_ctl_t            ctl,
    output logic [MAG_BITS-1:0]          mag [3]
);
    import tun_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int ES = edge_shift(COORD_BITS);
    localparam int EW = DW - ES;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;

    // difference, magnitude truncated toward zero when the coordinates are wide
    function automatic logic signed [EW-1:0] edge_diff(
        input logic signed [COORD_BITS-1:0] hi,
        input logic signed [COORD_BITS-1:0] lo
    );
        logic signed [DW-1:0] d;
        logic [DW-1:0]        m;
        logic [EW-1:0]        me;
        d  = DW'(hi) - DW'(lo);
        m  = d[DW-1] ? DW'(-d) : DW'(d);
        me = EW'(m >> ES);
        return d[DW-1] ? -$signed(me) : $signed(me);
    endfunction

    logic [2:0]           vld_reg, vld_next;
    logic signed [EW-1:0] a_reg [3], a_next [3];
    logic signed [EW-1:0] b_reg [3], b_next [3];
    logic signed [PW-1:0] prod_reg [6], prod_next [6];
    logic [MAG_BITS-1:0]  mag_reg [3], mag_next [3];
    logic [2:0]           neg_reg, neg_next;

    always_comb
    begin
        logic signed [CW-1:0] c;
        logic [CW-1:0]        cm;
        vld_next = {vld_reg[1:0], in_valid};
        for (int i = 0; i < 3; i++)
        begin
            a_next[i] = edge_diff(p[3+i], p[i]);
            b_next[i] = edge_diff(p[6+i], p[i]);
        end
        prod_next[0] = PW'(a_reg[1]) * PW'(b_reg[2]);
        prod_next[1] = PW'(a_reg[2]) * PW'(b_reg[1]);
        prod_next[2] = PW'(a_reg[2]) * PW'(b_reg[0]);
        prod_next[3] = PW'(a_reg[0]) * PW'(b_reg[2]);
        prod_next[4] = PW'(a_reg[0]) * PW'(b_reg[1]);
        prod_next[5] = PW'(a_reg[1]) * PW'(b_reg[0]);
        for (int i = 0; i < 3; i++)
        begin
            c           = CW'(prod_reg[2*i]) - CW'(prod_reg[2*i+1]);
            cm          = c[CW-1] ? CW'(-c) : CW'(c);
            neg_next[i] = c[CW-1];
            mag_next[i] = cm[MAG_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            prod_reg <= prod_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
        end
    end

    assign ctl = '{valid: vld_reg[2], degen: 1'b0, neg: neg_reg};
    assign mag = mag_reg;

endmodule

// File: rtl/tun_norm.sv
// Block normalization of the cross product, squares and sum of squares.
module tun_norm #(
    parameter int MAG_BITS = 2 * tun_pkg::edge_bits(tun_pkg::COORD_BITS_DEF)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  tun_pkg::tun_ctl_t              ctl_in,
    input  logic [MAG_BITS-1:0]            mag_in [3],
    output tun_pkg::tun_ctl_t              ctl_out,
    output logic [tun_pkg::SUM_BITS-1:0]   sum,
    output logic [tun_pkg::NMAG_BITS-1:0]  nmag [3]
);
    import tun_pkg::*;

    localparam int LW  = $clog2(MAG_BITS);
    localparam int XW  = (MAG_BITS > NMAG_BITS) ? MAG_BITS : NMAG_BITS;
    localparam int SQW = 2 * NMAG_BITS;

    tun_ctl_t             ctl_reg [4], ctl_next [4];
    logic [MAG_BITS-1:0]  mag_a_reg [3];
    logic [LW-1:0]        lead_reg, lead_next;
    logic [NMAG_BITS-1:0] nm_b_reg [3], nm_b_next [3];
    logic [NMAG_BITS-1:0] nm_c_reg [3];
    logic [SQW-1:0]       sq_reg [3], sq_next [3];
    logic [NMAG_BITS-1:0] nm_d_reg [3];
    logic [SUM_BITS-1:0]  sum_reg, sum_next;

    always_comb
    begin
        logic [MAG_BITS-1:0] ored;
        logic [XW-1:0]       ext;
        logic [XW-1:0]       shf;
        // leading one of the OR equals that of the largest magnitude
        ored      = mag_in[0] | mag_in[1] | mag_in[2];
        lead_next = '0;
        for (int i = 0; i < MAG_BITS; i++)
        begin
            if (ored[i])
                lead_next = LW'(i);
        end
        ctl_next[0]       = ctl_in;
        ctl_next[0].degen = (ored == '0);
        for (int k = 1; k < 4; k++)
            ctl_next[k] = ctl_reg[k-1];

        for (int i = 0; i < 3; i++)
        begin
            ext = XW'(mag_a_reg[i]);
            if (int'(lead_reg) >= NORM_MSB)
                shf = ext >> (int'(lead_reg) - NORM_MSB);
            else
                shf = ext << (NORM_MSB - int'(lead_reg));
            nm_b_next[i] = shf[NMAG_BITS-1:0];
            sq_next[i]   = SQW'(nm_b_reg[i]) * SQW'(nm_b_reg[i]);
        end
        sum_next = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                ctl_reg[k] <= '0;
        end
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg <= mag_in;
            lead_reg  <= lead_next;
            nm_b_reg  <= nm_b_next;
            nm_c_reg  <= nm_b_reg;
            sq_reg    <= sq_next;
            nm_d_reg  <= nm_c_reg;
            sum_reg   <= sum_next;
        end
    end

    assign ctl_out = ctl_reg[3];
    assign sum     = sum_reg;
    assign nmag    = nm_d_reg;

endmodule

// File: rtl/tun_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tun_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  tun_pkg::tun_ctl_t              ctl_in,
    input  logic [tun_pkg::SUM_BITS-1:0]   sum_in,
    input  logic [tun_pkg::NMAG_BITS-1:0]  nmag_in [3],
    output tun_pkg::tun_ctl_t              ctl_out,
    output logic [tun_pkg::ROOT_BITS-1:0]  root,
    output logic [tun_pkg::NMAG_BITS-1:0]  nmag_out [3]
);
    import tun_pkg::*;

    localparam int STEPS = ROOT_BITS;
    localparam int REMW  = ROOT_BITS + 2;

    tun_ctl_t             ctl_tap  [STEPS+1];
    logic [SUM_BITS-1:0]  rad_tap  [STEPS+1];
    logic [REMW-1:0]      rem_tap  [STEPS+1];
    logic [ROOT_BITS-1:0] root_tap [STEPS+1];
    logic [NMAG_BITS-1:0] nm_tap   [STEPS+1][3];

    assign ctl_tap[0]  = ctl_in;
    assign rad_tap[0]  = sum_in;
    assign rem_tap[0]  = '0;
    assign root_tap[0] = '0;
    assign nm_tap[0]   = nmag_in;

    genvar k;
    for (k = 0; k < STEPS; k++)
    begin : g_step
        tun_ctl_t             ctl_reg;
        logic [SUM_BITS-1:0]  rad_reg, rad_next;
        logic [REMW-1:0]      rem_reg, rem_next;
        logic [ROOT_BITS-1:0] root_reg, root_next;
        logic [NMAG_BITS-1:0] nm_reg [3];
        logic [REMW+1:0]      shr, trial, diff;
        logic                 take;

        always_comb
        begin
            shr       = {rem_tap[k], rad_tap[k][SUM_BITS-1 -: 2]};
            trial     = (REMW+2)'({root_tap[k], 2'b01});
            take      = (shr >= trial);
            diff      = shr - trial;
            rem_next  = take ? diff[REMW-1:0] : shr[REMW-1:0];
            root_next = {root_tap[k][ROOT_BITS-2:0], take};
            rad_next  = {rad_tap[k][SUM_BITS-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg <= '0;
            else if (en)
                ctl_reg <= ctl_tap[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg  <= rad_next;
                rem_reg  <= rem_next;
                root_reg <= root_next;
                nm_reg   <= nm_tap[k];
            end
        end

        assign ctl_tap[k+1]  = ctl_reg;
        assign rad_tap[k+1]  = rad_reg;
        assign rem_tap[k+1]  = rem_reg;
        assign root_tap[k+1] = root_reg;
        assign nm_tap[k+1]   = nm_reg;
    end

    assign ctl_out  = ctl_tap[STEPS];
    assign root     = root_tap[STEPS];
    assign nmag_out = nm_tap[STEPS];

endmodule

// File: rtl/tun_div.sv
// Three-lane pipelined restoring divider with rounding and output saturation.
module tun_div #(
    parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  tun_pkg::tun_ctl_t              ctl_in,
    input  logic [tun_pkg::ROOT_BITS-1:0]  root_in,
    input  logic [tun_pkg::NMAG_BITS-1:0]  nmag_in [3],
    output logic                           res_valid,
    output tun_pkg::tun_res_t              res
);
    import tun_pkg::*;

    localparam int QW      = NORM_FRAC_BITS + 1;
    localparam int NUMW    = NMAG_BITS + QW;
    localparam int XW      = (QW > OUT_BITS) ? QW + 1 : OUT_BITS + 1;
    localparam int POS_LIM = 2 ** (OUT_BITS - 1) - 1;
    localparam int NEG_LIM = 2 ** (OUT_BITS - 1);

    tun_ctl_t             ctl_tap [QW+1];
    logic [ROOT_BITS-1:0] den_tap [QW+1];
    logic [ROOT_BITS-1:0] r_tap   [QW+1][3];
    logic [QW-1:0]        lo_tap  [QW+1][3];
    logic [QW-1:0]        q_tap   [QW+1][3];

    // setup: numerator = mag * 2^F + L/2, remainder seeded with its upper bits
    tun_ctl_t             ctl0_reg;
    logic [ROOT_BITS-1:0] den0_reg;
    logic [ROOT_BITS-1:0] r0_reg [3], r0_next [3];
    logic [QW-1:0]        lo0_reg [3], lo0_next [3];

    always_comb
    begin
        logic [NUMW-1:0] num;
        for (int i = 0; i < 3; i++)
        begin
            num         = (NUMW'(nmag_in[i]) << NORM_FRAC_BITS) + NUMW'(root_in >> 1);
            r0_next[i]  = ROOT_BITS'(num[NUMW-1:QW]);
            lo0_next[i] = num[QW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (en)
            ctl0_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den0_reg <= root_in;
            r0_reg   <= r0_next;
            lo0_reg  <= lo0_next;
        end
    end

    assign ctl_tap[0] = ctl0_reg;
    assign den_tap[0] = den0_reg;
    assign r_tap[0]   = r0_reg;
    assign lo_tap[0]  = lo0_reg;
    for (genvar i = 0; i < 3; i++)
    begin : g_q0
        assign q_tap[0][i] = '0;
    end

    genvar k;
    for (k = 0; k < QW; k++)
    begin : g_bit
        tun_ctl_t             ctl_reg;
        logic [ROOT_BITS-1:0] den_reg;
        logic [ROOT_BITS-1:0] r_reg [3], r_next [3];
        logic [QW-1:0]        lo_reg [3], lo_next [3];
        logic [QW-1:0]        q_reg [3], q_next [3];

        always_comb
        begin
            logic [ROOT_BITS:0] r2;
            logic [ROOT_BITS:0] dx;
            logic               take;
            dx = {1'b0, den_tap[k]};
            for (int i = 0; i < 3; i++)
            begin
                r2         = {r_tap[k][i], lo_tap[k][i][QW-1]};
                take       = (r2 >= dx);
                r_next[i]  = take ? ROOT_BITS'(r2 - dx) : r2[ROOT_BITS-1:0];
                lo_next[i] = lo_tap[k][i] << 1;
                q_next[i]  = {q_tap[k][i][QW-2:0], take};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg <= '0;
            else if (en)
                ctl_reg <= ctl_tap[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg <= den_tap[k];
                r_reg   <= r_next;
                lo_reg  <= lo_next;
                q_reg   <= q_next;
            end
        end

        assign ctl_tap[k+1] = ctl_reg;
        assign den_tap[k+1] = den_reg;
        assign r_tap[k+1]   = r_reg;
        assign lo_tap[k+1]  = lo_reg;
        assign q_tap[k+1]   = q_reg;
    end

    // sign, saturation, zero on a degenerate triangle
    logic [OUT_BITS-1:0] comp [3];

    always_comb
    begin
        logic [XW-1:0] qx;
        logic [XW-1:0] mx;
        logic [XW-1:0] val;
        for (int i = 0; i < 3; i++)
        begin
            qx = XW'(q_tap[QW][i]);
            if (ctl_tap[QW].neg[i])
            begin
                mx  = (qx > XW'(NEG_LIM)) ? XW'(NEG_LIM) : qx;
                val = -mx;
            end
            else
            begin
                mx  = (qx > XW'(POS_LIM)) ? XW'(POS_LIM) : qx;
                val = mx;
            end
            comp[i] = ctl_tap[QW].degen ? '0 : val[OUT_BITS-1:0];
        end
    end

    assign res_valid = ctl_tap[QW].valid;
    assign res.x     = $signed(comp[0]);
    assign res.y     = $signed(comp[1]);
    assign res.z     = $signed(comp[2]);
    assign res.degen = ctl_tap[QW].degen;

endmodule

// File: rtl/triangle_unit_normal.sv
// Top level of the triangle unit normal pipeline.
// Takes one triangle per clock while in_ready is high and returns its unit normal
// (Q1.x, NORM_FRAC_BITS fraction bits). A triangle passes, in order, the edge and
// cross-product registers, normalization and the sum of squares, the 32-stage
// square root, divider setup, the NORM_FRAC_BITS + 1 stage divider and the output
// register. Every stage holds while a skid word is parked at the output, so a single
// stalled result does not stop input; a longer stall on out_ready holds the whole
// pipe with nothing dropped. A triangle whose cross product is zero gives zero
// components and degenerate high.
module triangle_unit_normal #(
    parameter int COORD_BITS     = tun_pkg::COORD_BITS_DEF,
    parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        p1_x,
    input  logic signed [COORD_BITS-1:0]        p1_y,
    input  logic signed [COORD_BITS-1:0]        p1_z,
    input  logic signed [COORD_BITS-1:0]        p2_x,
    input  logic signed [COORD_BITS-1:0]        p2_y,
    input  logic signed [COORD_BITS-1:0]        p2_z,
    input  logic signed [COORD_BITS-1:0]        p3_x,
    input  logic signed [COORD_BITS-1:0]        p3_y,
    input  logic signed [COORD_BITS-1:0]        p3_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tun_pkg::OUT_BITS-1:0] norm_x,
    output logic signed [tun_pkg::OUT_BITS-1:0] norm_y,
    output logic signed [tun_pkg::OUT_BITS-1:0] norm_z,
    output logic                                degenerate
);
    import tun_pkg::*;

    localparam int MAG_BITS = 2 * edge_bits(COORD_BITS);

    logic                         en;
    logic signed [COORD_BITS-1:0] pts [9];

    tun_ctl_t             ctl_cross, ctl_norm, ctl_sqrt;
    logic [MAG_BITS-1:0]  mag [3];
    logic [SUM_BITS-1:0]  sum;
    logic [NMAG_BITS-1:0] nmag_n [3], nmag_s [3];
    logic [ROOT_BITS-1:0] root;
    logic                 res_valid;
    tun_res_t             res;

    assign pts = '{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z};

    tun_cross #(
        .COORD_BITS (COORD_BITS),
        .MAG_BITS   (MAG_BITS)
    ) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .p        (pts),
        .ctl      (ctl_cross),
        .mag      (mag)
    );

    tun_norm #(
        .MAG_BITS (MAG_BITS)
    ) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_cross),
        .mag_in  (mag),
        .ctl_out (ctl_norm),
        .sum     (sum),
        .nmag    (nmag_n)
    );

    tun_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_norm),
        .sum_in   (sum),
        .nmag_in  (nmag_n),
        .ctl_out  (ctl_sqrt),
        .root     (root),
        .nmag_out (nmag_s)
    );

    tun_div #(
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_sqrt),
        .root_in   (root),
        .nmag_in   (nmag_s),
        .res_valid (res_valid),
        .res       (res)
    );

    // output word plus one skid word; the pipe advances while the skid is empty
    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    tun_res_t out_res_reg, out_res_next;
    tun_res_t skid_res_reg, skid_res_next;
    logic     push;

    assign en   = !skid_valid_reg;
    assign push = en && res_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready   = en;
    assign out_valid  = out_valid_reg;
    assign norm_x     = out_res_reg.x;
    assign norm_y     = out_res_reg.y;
    assign norm_z     = out_res_reg.z;
    assign degenerate = out_res_reg.degen;

endmodule

// File: rtl/tun_checker.sv
// Port-level assertions for the triangle unit normal, bound to the top level.
`include "triangle_unit_normal_defines.svh"

module tun_checker #(
    parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [tun_pkg::OUT_BITS-1:0] norm_x,
    input logic signed [tun_pkg::OUT_BITS-1:0] norm_y,
    input logic signed [tun_pkg::OUT_BITS-1:0] norm_z,
    input logic                                degenerate
);
    import tun_pkg::*;

    localparam int UNIT    = 2 ** NORM_FRAC_BITS;
    localparam int POS_LIM = (UNIT < 2 ** (OUT_BITS - 1)) ? UNIT : 2 ** (OUT_BITS - 1) - 1;
    localparam int NEG_LIM = (UNIT < 2 ** (OUT_BITS - 1)) ? UNIT : 2 ** (OUT_BITS - 1);

    // degenerate word carries an all-zero normal
    `TUN_ASSERT_NOW(a_degen_zero, out_valid && degenerate, norm_x == 0 && norm_y == 0 && norm_z == 0, "degenerate word with nonzero normal")

    // a real triangle never normalizes to the zero vector
    `TUN_ASSERT_NOW(a_nonzero, out_valid && !degenerate, norm_x != 0 || norm_y != 0 || norm_z != 0, "nondegenerate word with zero normal")

    // no component exceeds unit length
    `TUN_ASSERT_NOW(a_range, out_valid, norm_x <= POS_LIM && norm_x >= -NEG_LIM && norm_y <= POS_LIM && norm_y >= -NEG_LIM && norm_z <= POS_LIM && norm_z >= -NEG_LIM, "normal component beyond unit range")

    // a stalled result word stays put
    `TUN_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(norm_x) && $stable(norm_y) && $stable(norm_z) && $stable(degenerate), "output word changed while stalled")

endmodule

bind triangle_unit_normal tun_checker #(
    .NORM_FRAC_BITS (NORM_FRAC_BITS)
) u_tun_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
);

// File: verif/tb.sv
// Testbench for the triangle unit normal pipeline.
`timescale 1ns / 100ps

module tb;

    localparam int CB = tun_pkg::COORD_BITS_DEF;
    localparam int FB = tun_pkg::NORM_FRAC_DEF;
    localparam int OB = tun_pkg::OUT_BITS;
    localparam int MAX_CYCLES = 400000;

    typedef logic signed [CB-1:0] coord_t;
    typedef coord_t tri_t [9];

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    coord_t p1_x = '0, p1_y = '0, p1_z = '0;
    coord_t p2_x = '0, p2_y = '0, p2_z = '0;
    coord_t p3_x = '0, p3_y = '0, p3_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OB-1:0] norm_x, norm_y, norm_z;
    logic degenerate;

    tun_pkg::tun_res_t normal_q [$];
    int mismatches = 0;
    int cycles = 0;
    bit hold_off = 0;
    bit rx_busy = 0;

    triangle_unit_normal DUT (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("triangle_unit_normal test failed");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(input logic [63:0] s);
        logic [63:0] root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (s >= root + bit_v)
            begin
                s -= root + bit_v;
                root = (root >> 1) + bit_v;
            end
            else
                root >>= 1;
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic tun_pkg::tun_res_t unit_normal(input tri_t p);
        longint a [3], b [3], c [3];
        logic [63:0] mag [3], m, s, len, q;
        logic negs [3];
        longint v;
        int sh;
        logic signed [OB-1:0] comp [3];
        tun_pkg::tun_res_t r;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'(p[3+i]) - longint'(p[i]);
            b[i] = longint'(p[6+i]) - longint'(p[i]);
        end
        c[0] = a[1]*b[2] - a[2]*b[1];
        c[1] = a[2]*b[0] - a[0]*b[2];
        c[2] = a[0]*b[1] - a[1]*b[0];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            negs[i] = c[i] < 0;
            mag[i] = negs[i] ? -c[i] : c[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
            return '{x: '0, y: '0, z: '0, degen: 1'b1};
        sh = 0;
        while (m >= (64'd1 << 31))
        begin
            m >>= 1;
            sh--;
        end
        while (m < (64'd1 << 30))
        begin
            m <<= 1;
            sh++;
        end
        for (int i = 0; i < 3; i++)
            mag[i] = (sh >= 0) ? mag[i] << sh : mag[i] >> -sh;
        s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
        len = isqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FB) + (len >> 1)) / len;
            if (q > (64'd1 << 40))
                q = 64'd1 << 40;
            v = negs[i] ? -longint'(q) : longint'(q);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            comp[i] = v[OB-1:0];
        end
        r.x = comp[0];
        r.y = comp[1];
        r.z = comp[2];
        r.degen = 1'b0;
        return r;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                rx_busy = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
                rx_busy = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 1)) gap = 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            out_ready <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        tun_pkg::tun_res_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (normal_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %0d %0d %0d %0b",
                             norm_x, norm_y, norm_z, degenerate);
            end
            else
            begin
                exp_r = normal_q.pop_front();
                if (norm_x !== exp_r.x || norm_y !== exp_r.y || norm_z !== exp_r.z
                    || degenerate !== exp_r.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                 exp_r.x, exp_r.y, exp_r.z, exp_r.degen,
                                 norm_x, norm_y, norm_z, degenerate);
                end
            end
        end
    end

    task automatic send_tri(input tri_t p, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {p1_x, p1_y, p1_z} <= {p[0], p[1], p[2]};
        {p2_x, p2_y, p2_z} <= {p[3], p[4], p[5]};
        {p3_x, p3_y, p3_z} <= {p[6], p[7], p[8]};
        do @(posedge clk); while (!in_ready);
        normal_q.push_back(unit_normal(p));
    endtask

    function automatic coord_t rand_coord(input int range_sel);
        case (range_sel)
            0: return coord_t'($urandom_range(0, 32) - 16);
            1: return coord_t'($urandom_range(0, 2048) - 1024);
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        tri_t p;
        int lims [4] = '{32767, -32768, 0, 1};
        p = '{default: 0};
        send_tri(p, 0);                                    // all corners equal
        p = '{0, 0, 0, 256, 0, 0, 0, 256, 0};              // right triangle, legs of 256
        send_tri(p, 0);
        p = '{0, 0, 0, 256, 256, 256, 512, 512, 512};      // collinear
        send_tri(p, 0);
        p = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        send_tri(p, 0);
        p = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        send_tri(p, 0);
        p = '{0, 0, 0, 1, 0, 0, 0, 0, 1};                  // tiny edges
        send_tri(p, 0);
        p = '{0, 0, 0, 1, 1, 0, 1, 0, 1};
        send_tri(p, 0);
        p = '{-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768};
        send_tri(p, 0);
        for (int k = 0; k < 12; k++)
        begin
            for (int i = 0; i < 9; i++)
                p[i] = coord_t'(lims[$urandom_range(0, 3)]);
            send_tri(p, 0);
        end
    endtask

    task automatic test_random(input int count);
        tri_t p;
        int sel;
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                p[i] = rand_coord(sel);
            if ($urandom_range(0, 15) == 0)
            begin
                // degenerate: third corner repeats the first
                for (int i = 0; i < 3; i++)
                    p[6+i] = p[i];
            end
            send_tri(p, (k % 100) >= 70);
        end
    endtask

    task automatic test_backpressure();
        tri_t p;
        hold_off = 1;
        for (int k = 0; k < 100; k++)
        begin
            for (int i = 0; i < 9; i++)
                p[i] = rand_coord(3);
            send_tri(p, 1);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(140);
        test_backpressure();
        test_random(140);
        in_valid <= 1'b0;
        while (normal_q.size() != 0 || rx_busy)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && normal_q.size() == 0)
            $display("triangle_unit_normal test passed");
        else
            $display("triangle_unit_normal test failed");
        $finish;
    end

endmodule
